FILE: hw/rtl/arpc_pkg.sv
// Shared types and constants of the ARP cache engine.
package arpc_pkg;

   localparam int REQ_DATA_W = 224;
   localparam int RSP_DATA_W = 184;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;

   localparam logic [10:0] MIN_MSG_LEN   = 11'd28;
   localparam logic [15:0] HW_ETHER      = 16'h0001;
   localparam logic [15:0] PROTO_IPV4    = 16'h0800;
   localparam logic [7:0]  HW_ADDR_LEN   = 8'd6;
   localparam logic [7:0]  PROTO_ADDR_LEN = 8'd4;
   localparam logic [15:0] ARP_CODE_REQ  = 16'h0001;
   localparam logic [15:0] TIMEOUT_RESET = 16'd30;
   localparam logic [47:0] MAC_BROADCAST = 48'hFFFF_FFFF_FFFF;

   typedef enum logic [1:0] {
      OP_RX      = 2'd0,
      OP_RESOLVE = 2'd1,
      OP_TICK    = 2'd2
   } arpc_op_type;

   typedef enum logic [2:0] {
      RS_ACCEPTED   = 3'd0,
      RS_TOO_SHORT  = 3'd1,
      RS_BAD_HW     = 3'd2,
      RS_BAD_PROTO  = 3'd3,
      RS_FOUND      = 3'd4,
      RS_INCOMPLETE = 3'd5,
      RS_ERROR      = 3'd6,
      RS_TICK_DONE  = 3'd7
   } arpc_status_type;

   typedef enum logic [1:0] {
      ENT_FREE       = 2'd0,
      ENT_INCOMPLETE = 2'd1,
      ENT_RESOLVED   = 2'd2
   } arpc_ent_type;

   typedef enum logic [2:0] {
      REG_LOCAL_IP   = 3'd0,
      REG_LOCAL_MAC  = 3'd1,
      REG_TIMEOUT    = 3'd2,
      REG_IFACE      = 3'd3,
      REG_DEVICE_ETH = 3'd4
   } arpc_reg_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_APPLY
   } arpc_fsm_type;

   typedef struct packed {
      logic clear;
      logic en;
      logic age_en;
   } arpc_scan_ctl_type;

   typedef struct packed {
      logic found;
      logic found_res;
      logic has_free;
      logic expire;
   } arpc_hit_type;

endpackage

FILE: hw/rtl/arpc_table.sv
// Entry storage: state flops plus IP, MAC and stamp memories with registered read.
module arpc_table #(
   parameter int ENTRIES = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rd_en,
   input  logic [$clog2(ENTRIES)-1:0]    rd_addr,
   input  logic                          wr_en,
   input  logic [$clog2(ENTRIES)-1:0]    wr_idx,
   input  logic [31:0]                   wr_ip,
   input  logic [47:0]                   wr_mac,
   input  logic [31:0]                   wr_stamp,
   input  logic                          st_wr_en,
   input  logic [$clog2(ENTRIES)-1:0]    st_wr_idx,
   input  arpc_pkg::arpc_ent_type        st_wr_val,
   output logic                          rd_vld,
   output logic [$clog2(ENTRIES)-1:0]    rd_idx,
   output arpc_pkg::arpc_ent_type        rd_st,
   output logic [31:0]                   rd_ip,
   output logic [47:0]                   rd_mac,
   output logic [31:0]                   rd_stamp
);
   import arpc_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);

   arpc_ent_type             st_ff [ENTRIES];
   logic [31:0]              ip_mem [ENTRIES];
   logic [47:0]              mac_mem [ENTRIES];
   logic [31:0]              stamp_mem [ENTRIES];
   logic                     rd_vld_ff;
   logic [IDX_W-1:0]         rd_idx_ff;
   arpc_ent_type             rd_st_ff;
   logic [31:0]              rd_ip_ff;
   logic [47:0]              rd_mac_ff;
   logic [31:0]              rd_stamp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            st_ff[i] <= ENT_FREE;
         end
         rd_vld_ff <= 1'b0;
      end else begin
         if (st_wr_en) begin
            st_ff[st_wr_idx] <= st_wr_val;
         end
         rd_vld_ff <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_idx_ff <= rd_addr;
         rd_st_ff  <= st_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ip_mem[wr_idx]    <= wr_ip;
         mac_mem[wr_idx]   <= wr_mac;
         stamp_mem[wr_idx] <= wr_stamp;
      end
      if (rd_en) begin
         rd_ip_ff    <= ip_mem[rd_addr];
         rd_mac_ff   <= mac_mem[rd_addr];
         rd_stamp_ff <= stamp_mem[rd_addr];
      end
   end

   assign rd_vld   = rd_vld_ff;
   assign rd_idx   = rd_idx_ff;
   assign rd_st    = rd_st_ff;
   assign rd_ip    = rd_ip_ff;
   assign rd_mac   = rd_mac_ff;
   assign rd_stamp = rd_stamp_ff;

endmodule

FILE: hw/rtl/arpc_scan.sv
// Shared compare unit: match, age, expiry and allocation tracking, one entry per cycle.
module arpc_scan #(
   parameter int ENTRIES = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  arpc_pkg::arpc_scan_ctl_type   ctl,
   input  logic [$clog2(ENTRIES)-1:0]    idx,
   input  arpc_pkg::arpc_ent_type        st,
   input  logic [31:0]                   ip,
   input  logic [47:0]                   mac,
   input  logic [31:0]                   stamp,
   input  logic [31:0]                   key,
   input  logic [31:0]                   now,
   input  logic [15:0]                   timeout,
   output arpc_pkg::arpc_hit_type        hit,
   output logic [$clog2(ENTRIES)-1:0]    found_idx,
   output logic [47:0]                   found_mac,
   output logic [$clog2(ENTRIES)-1:0]    alloc_idx
);
   import arpc_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);

   logic              found_ff;
   logic              found_res_ff;
   logic [IDX_W-1:0]  found_idx_ff;
   logic [47:0]       found_mac_ff;
   logic              free_ff;
   logic [IDX_W-1:0]  free_idx_ff;
   logic              first_ff;
   logic [31:0]       best_age_ff;
   logic [IDX_W-1:0]  best_idx_ff;
   logic              live;
   logic              ip_match;
   logic [31:0]       age;

   assign live     = (st != ENT_FREE);
   assign ip_match = (ip == key);
   assign age      = now - stamp;

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         found_ff <= 1'b0;
         free_ff  <= 1'b0;
         first_ff <= 1'b1;
      end else if (ctl.en) begin
         if (live && ip_match && !found_ff) begin
            found_ff <= 1'b1;
         end
         if (!live && !free_ff) begin
            free_ff <= 1'b1;
         end
         first_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         if (live && ip_match && !found_ff) begin
            found_idx_ff <= idx;
            found_mac_ff <= mac;
            found_res_ff <= (st == ENT_RESOLVED);
         end
         if (!live && !free_ff) begin
            free_idx_ff <= idx;
         end
         if (live && (first_ff || age > best_age_ff)) begin
            best_age_ff <= age;
            best_idx_ff <= idx;
         end
      end
   end

   assign hit.found     = found_ff;
   assign hit.found_res = found_res_ff;
   assign hit.has_free  = free_ff;
   assign hit.expire    = ctl.en && ctl.age_en && live && (age > 32'(timeout));
   assign found_idx     = found_idx_ff;
   assign found_mac     = found_mac_ff;
   assign alloc_idx     = free_ff ? free_idx_ff : best_idx_ff;

endmodule

FILE: hw/rtl/arp_cache_engine.sv
// ARP cache engine top level: sequencer, item and configuration registers, result register.
//
//  channel  | dir | handshake             | payload
//  ---------+-----+-----------------------+------------------------------------------
//  req_     | in  | req_tvalid/req_tready | tuser opcode, tdata ARP header + addresses
//  rsp_     | out | rsp_tvalid/rsp_tready | tuser status, tdata send fields + MAC
//  csr_     | in  | psel/penable, pready  | 64-bit registers at 8*index
//
//  An item that touches the table passes accept, a scan of all CACHE_ENTRIES entries (one table
//  read per cycle through the shared compare unit) and an update step; its result is registered
//  at the update. Rejected headers, resolve errors and unused opcodes skip the scan.
//  Reset clears all entry states at once; the block is ready the cycle after reset.
//  A held result stalls only the update step; the next item is taken once that step is done.
module arp_cache_engine #(
   parameter int CACHE_ENTRIES = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // opcode
   input  logic [1:0]                        req_tuser,
   // msg_len, hw_type, proto_type, hw_len, proto_len, arp_op, sender_mac, sender_ip,
   // target_ip, lookup_ip
   input  logic [arpc_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // status
   output logic [2:0]                        rsp_tuser,
   // send_valid, send_is_reply, send_dest_mac, send_target_mac, send_target_ip,
   // resolved_mac
   output logic [arpc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [arpc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [arpc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [arpc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import arpc_pkg::*;

   localparam int IDX_W = $clog2(CACHE_ENTRIES);
   localparam int CNT_W = IDX_W + 1;

   arpc_fsm_type       state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [31:0]        now_ff, now_in;
   logic               rsp_valid_ff, rsp_valid_in;
   arpc_status_type    rsp_status_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic [31:0]        local_ip_ff;
   logic [47:0]        local_mac_ff;
   logic [15:0]        timeout_ff;
   logic               iface_ff;
   logic               eth_ff;

   arpc_op_type        op_ff;
   arpc_status_type    pre_status_ff;
   logic               ok_ff;
   logic               is_req_ff;
   logic [31:0]        key_ff;
   logic [47:0]        sender_mac_ff;
   logic [31:0]        target_ip_ff;

   logic               accept;
   logic               rd_en;
   logic               apply_go;
   logic               do_scan;
   arpc_status_type    hdr_status;
   logic               csr_wr;

   logic [10:0]        in_msg_len;
   logic [15:0]        in_hw_type;
   logic [15:0]        in_proto_type;
   logic [7:0]         in_hw_len;
   logic [7:0]         in_proto_len;
   logic [15:0]        in_arp_op;
   logic [47:0]        in_sender_mac;
   logic [31:0]        in_sender_ip;
   logic [31:0]        in_target_ip;
   logic [31:0]        in_lookup_ip;

   logic               tbl_vld;
   logic [IDX_W-1:0]   tbl_idx;
   arpc_ent_type       tbl_st;
   logic [31:0]        tbl_ip;
   logic [47:0]        tbl_mac;
   logic [31:0]        tbl_stamp;

   arpc_scan_ctl_type  scan_ctl;
   arpc_hit_type       hit;
   logic [IDX_W-1:0]   found_idx;
   logic [47:0]        found_mac;
   logic [IDX_W-1:0]   alloc_idx;

   logic               ap_wr;
   logic [IDX_W-1:0]   ap_idx;
   arpc_ent_type       ap_st;
   logic [47:0]        ap_mac;
   arpc_status_type    res_status;
   logic               res_sv;
   logic               res_rep;
   logic [47:0]        res_dst;
   logic [47:0]        res_tha;
   logic [31:0]        res_tip;
   logic [47:0]        res_rmac;
   logic               for_us;

   logic               tbl_wr_en;
   logic               st_wr_en;
   logic [IDX_W-1:0]   st_wr_idx;
   arpc_ent_type       st_wr_val;

   assign in_msg_len    = req_tdata[10:0];
   assign in_hw_type    = req_tdata[26:11];
   assign in_proto_type = req_tdata[42:27];
   assign in_hw_len     = req_tdata[50:43];
   assign in_proto_len  = req_tdata[58:51];
   assign in_arp_op     = req_tdata[74:59];
   assign in_sender_mac = req_tdata[122:75];
   assign in_sender_ip  = req_tdata[154:123];
   assign in_target_ip  = req_tdata[186:155];
   assign in_lookup_ip  = req_tdata[218:187];

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         local_ip_ff  <= 32'd0;
         local_mac_ff <= 48'd0;
         timeout_ff   <= TIMEOUT_RESET;
         iface_ff     <= 1'b1;
         eth_ff       <= 1'b1;
      end else if (csr_wr) begin
         case (csr_paddr[5:3])
            REG_LOCAL_IP:   local_ip_ff  <= csr_pwdata[31:0];
            REG_LOCAL_MAC:  local_mac_ff <= csr_pwdata[47:0];
            REG_TIMEOUT:    timeout_ff   <= csr_pwdata[15:0];
            REG_IFACE:      iface_ff     <= csr_pwdata[0];
            REG_DEVICE_ETH: eth_ff       <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[5:3])
         REG_LOCAL_IP:   csr_prdata = {32'd0, local_ip_ff};
         REG_LOCAL_MAC:  csr_prdata = {16'd0, local_mac_ff};
         REG_TIMEOUT:    csr_prdata = {48'd0, timeout_ff};
         REG_IFACE:      csr_prdata = {63'd0, iface_ff};
         REG_DEVICE_ETH: csr_prdata = {63'd0, eth_ff};
         default:        csr_prdata = '0;
      endcase
   end

   // header checks and scan decision at accept
   always_comb begin
      if (in_msg_len < MIN_MSG_LEN) begin
         hdr_status = RS_TOO_SHORT;
      end else if (in_hw_type != HW_ETHER || in_hw_len != HW_ADDR_LEN) begin
         hdr_status = RS_BAD_HW;
      end else if (in_proto_type != PROTO_IPV4 || in_proto_len != PROTO_ADDR_LEN) begin
         hdr_status = RS_BAD_PROTO;
      end else begin
         hdr_status = RS_ACCEPTED;
      end
      case (req_tuser)
         OP_RX:      do_scan = (hdr_status == RS_ACCEPTED);
         OP_RESOLVE: do_scan = eth_ff && iface_ff;
         OP_TICK:    do_scan = 1'b1;
         default:    do_scan = 1'b0;
      endcase
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      req_tready = 1'b0;
      accept     = 1'b0;
      rd_en      = 1'b0;
      apply_go   = 1'b0;
      case (state_ff)
         FSM_IDLE: begin
            req_tready = 1'b1;
            accept     = req_tvalid;
            cnt_in     = '0;
            if (req_tvalid) begin
               state_in = do_scan ? FSM_SCAN : FSM_APPLY;
            end
         end
         FSM_SCAN: begin
            rd_en = (cnt_ff < CNT_W'(CACHE_ENTRIES));
            if (rd_en) begin
               cnt_in = cnt_ff + 1'b1;
            end
            if (tbl_vld && tbl_idx == IDX_W'(CACHE_ENTRIES - 1)) begin
               state_in = FSM_APPLY;
            end
         end
         FSM_APPLY: begin
            apply_go = !rsp_valid_ff || rsp_tready;
            if (apply_go) begin
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   assign now_in = (accept && req_tuser == OP_TICK) ? now_ff + 32'd1 : now_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         cnt_ff       <= '0;
         now_ff       <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         now_ff       <= now_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff         <= arpc_op_type'(req_tuser);
         pre_status_ff <= hdr_status;
         ok_ff         <= do_scan;
         is_req_ff     <= (in_arp_op == ARP_CODE_REQ);
         key_ff        <= (req_tuser == OP_RESOLVE) ? in_lookup_ip : in_sender_ip;
         sender_mac_ff <= in_sender_mac;
         target_ip_ff  <= in_target_ip;
      end
   end

   // table and compare unit
   assign scan_ctl.clear  = accept;
   assign scan_ctl.en     = (state_ff == FSM_SCAN) && tbl_vld;
   assign scan_ctl.age_en = (op_ff == OP_TICK);

   arpc_table #(
      .ENTRIES (CACHE_ENTRIES)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (rd_en),
      .rd_addr   (cnt_ff[IDX_W-1:0]),
      .wr_en     (tbl_wr_en),
      .wr_idx    (ap_idx),
      .wr_ip     (key_ff),
      .wr_mac    (ap_mac),
      .wr_stamp  (now_ff),
      .st_wr_en  (st_wr_en),
      .st_wr_idx (st_wr_idx),
      .st_wr_val (st_wr_val),
      .rd_vld    (tbl_vld),
      .rd_idx    (tbl_idx),
      .rd_st     (tbl_st),
      .rd_ip     (tbl_ip),
      .rd_mac    (tbl_mac),
      .rd_stamp  (tbl_stamp)
   );

   arpc_scan #(
      .ENTRIES (CACHE_ENTRIES)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .ctl       (scan_ctl),
      .idx       (tbl_idx),
      .st        (tbl_st),
      .ip        (tbl_ip),
      .mac       (tbl_mac),
      .stamp     (tbl_stamp),
      .key       (key_ff),
      .now       (now_ff),
      .timeout   (timeout_ff),
      .hit       (hit),
      .found_idx (found_idx),
      .found_mac (found_mac),
      .alloc_idx (alloc_idx)
   );

   // update and result
   assign for_us = iface_ff && (local_ip_ff == target_ip_ff);

   always_comb begin
      ap_wr      = 1'b0;
      ap_idx     = alloc_idx;
      ap_st      = ENT_RESOLVED;
      ap_mac     = sender_mac_ff;
      res_status = RS_ERROR;
      res_sv     = 1'b0;
      res_rep    = 1'b0;
      res_dst    = 48'd0;
      res_tha    = 48'd0;
      res_tip    = 32'd0;
      res_rmac   = 48'd0;
      case (op_ff)
         OP_RX: begin
            if (!ok_ff) begin
               res_status = pre_status_ff;
            end else begin
               res_status = RS_ACCEPTED;
               if (hit.found) begin
                  ap_wr  = 1'b1;
                  ap_idx = found_idx;
               end else if (for_us) begin
                  ap_wr = 1'b1;
               end
               if (for_us && is_req_ff) begin
                  res_sv  = 1'b1;
                  res_rep = 1'b1;
                  res_dst = sender_mac_ff;
                  res_tha = sender_mac_ff;
                  res_tip = key_ff;
               end
            end
         end
         OP_RESOLVE: begin
            ap_st  = ENT_INCOMPLETE;
            ap_mac = 48'd0;
            if (ok_ff) begin
               if (hit.found && hit.found_res) begin
                  res_status = RS_FOUND;
                  res_rmac   = found_mac;
               end else begin
                  ap_wr      = !hit.found;
                  res_status = RS_INCOMPLETE;
                  res_sv     = 1'b1;
                  res_dst    = MAC_BROADCAST;
                  res_tip    = key_ff;
               end
            end
         end
         OP_TICK:  res_status = RS_TICK_DONE;
         default:  res_status = RS_ERROR;
      endcase
   end

   assign tbl_wr_en = apply_go && ap_wr;
   assign st_wr_en  = tbl_wr_en || hit.expire;
   assign st_wr_idx = tbl_wr_en ? ap_idx : tbl_idx;
   assign st_wr_val = tbl_wr_en ? ap_st : ENT_FREE;

   assign rsp_valid_in = apply_go || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (apply_go) begin
         rsp_status_ff <= res_status;
         rsp_data_ff   <= {6'd0, res_rmac, res_tip, res_tha, res_dst, res_rep, res_sv};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = rsp_data_ff;

   assert property (@(posedge clock) disable iff (reset)
      tbl_vld |-> state_ff == FSM_SCAN)
      else $error("table read outside scan");

   assert property (@(posedge clock) disable iff (reset)
      tbl_wr_en |-> state_ff == FSM_APPLY && !hit.expire)
      else $error("entry write outside update");

   assert property (@(posedge clock) disable iff (reset)
      hit.expire |-> op_ff == OP_TICK)
      else $error("entry aged out on a non-tick item");

   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == OP_TICK) |=> now_ff == $past(now_ff) + 32'd1)
      else $error("tick did not advance time");

endmodule

FILE: sim/tb_arp_cache_engine.sv
// Self-checking testbench for the ARP cache engine: stream driver, response checker, APB setup.
`timescale 1ns / 100ps

module tb_arp_cache_engine;
   import arpc_pkg::*;

   localparam int          NUM_ENTRIES  = 32;
   localparam int          DRAIN_CYCLES = 40;
   localparam logic [1:0]  OP_UNUSED    = 2'd3;
   localparam logic [15:0] ARP_CODE_REP = 16'h0002;

   typedef struct packed {
      logic [4:0]  pad;
      logic [31:0] lookup_ip;
      logic [31:0] target_ip;
      logic [31:0] sender_ip;
      logic [47:0] sender_mac;
      logic [15:0] arp_op;
      logic [7:0]  proto_len;
      logic [7:0]  hw_len;
      logic [15:0] proto_type;
      logic [15:0] hw_type;
      logic [10:0] msg_len;
   } arp_fields_type;

   typedef struct packed {
      logic [1:0]     opcode;
      arp_fields_type fields;
   } arp_item_type;

   typedef struct packed {
      logic [5:0]  pad;
      logic [47:0] resolved_mac;
      logic [31:0] send_target_ip;
      logic [47:0] send_target_mac;
      logic [47:0] send_dest_mac;
      logic        send_is_reply;
      logic        send_valid;
   } arp_rsp_fields_type;

   typedef struct packed {
      arpc_status_type    status;
      arp_rsp_fields_type fld;
   } arp_answer_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [1:0]            req_tuser = '0;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [2:0]            rsp_tuser;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   arp_cache_engine #(
      .CACHE_ENTRIES(NUM_ENTRIES)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tuser(req_tuser),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tuser(rsp_tuser),
      .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shadow of the configuration registers and the table
   logic [31:0]     cfg_local_ip = '0;
   logic [47:0]     cfg_local_mac = '0;
   logic [15:0]     cfg_timeout = TIMEOUT_RESET;
   logic            cfg_iface = 1'b1;
   logic            cfg_ether = 1'b1;

   arpc_ent_type    slot_state [NUM_ENTRIES];
   logic [31:0]     slot_ip    [NUM_ENTRIES];
   logic [47:0]     slot_mac   [NUM_ENTRIES];
   logic [31:0]     slot_stamp [NUM_ENTRIES];
   logic [31:0]     now_ticks = '0;

   arp_item_type    queued_msgs [$];
   arp_answer_type  awaited_answers [$];
   logic [31:0]     ip_pool [$];
   int              fail_count = 0;

   task automatic report_mismatch(input string msg);
      fail_count++;
      if (fail_count <= 40)
         $display("ERROR @%0t: %s", $time, msg);
   endtask

   function automatic int find_slot(input logic [31:0] ip);
      for (int i = 0; i < NUM_ENTRIES; i++)
         if (slot_state[i] != ENT_FREE && slot_ip[i] == ip)
            return i;
      return -1;
   endfunction

   // first free entry, else the oldest one, lowest index on a tie
   function automatic int victim_slot();
      int          best;
      logic [31:0] best_age;
      logic [31:0] age;
      best = 0;
      best_age = '0;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         if (slot_state[i] == ENT_FREE)
            return i;
         age = now_ticks - slot_stamp[i];
         if (i == 0 || age > best_age) begin
            best = i;
            best_age = age;
         end
      end
      return best;
   endfunction

   task automatic arp_table_step(input arp_item_type it);
      arp_answer_type want;
      arp_fields_type f;
      int             slot;
      logic           merged;
      f = it.fields;
      want = '0;
      want.status = RS_ERROR;
      merged = 1'b0;
      case (it.opcode)
         OP_RX: begin
            if (f.msg_len < MIN_MSG_LEN)
               want.status = RS_TOO_SHORT;
            else if (f.hw_type != HW_ETHER || f.hw_len != HW_ADDR_LEN)
               want.status = RS_BAD_HW;
            else if (f.proto_type != PROTO_IPV4 || f.proto_len != PROTO_ADDR_LEN)
               want.status = RS_BAD_PROTO;
            else begin
               want.status = RS_ACCEPTED;
               slot = find_slot(f.sender_ip);
               if (slot >= 0) begin
                  slot_state[slot] = ENT_RESOLVED;
                  slot_mac[slot] = f.sender_mac;
                  slot_stamp[slot] = now_ticks;
                  merged = 1'b1;
               end
               if (cfg_iface && cfg_local_ip == f.target_ip) begin
                  if (!merged) begin
                     slot = victim_slot();
                     slot_state[slot] = ENT_RESOLVED;
                     slot_ip[slot] = f.sender_ip;
                     slot_mac[slot] = f.sender_mac;
                     slot_stamp[slot] = now_ticks;
                  end
                  if (f.arp_op == ARP_CODE_REQ) begin
                     want.fld.send_valid = 1'b1;
                     want.fld.send_is_reply = 1'b1;
                     want.fld.send_dest_mac = f.sender_mac;
                     want.fld.send_target_mac = f.sender_mac;
                     want.fld.send_target_ip = f.sender_ip;
                  end
               end
            end
         end
         OP_RESOLVE: begin
            if (cfg_ether && cfg_iface) begin
               slot = find_slot(f.lookup_ip);
               if (slot < 0 || slot_state[slot] == ENT_INCOMPLETE) begin
                  if (slot < 0) begin
                     slot = victim_slot();
                     slot_state[slot] = ENT_INCOMPLETE;
                     slot_ip[slot] = f.lookup_ip;
                     slot_mac[slot] = '0;
                     slot_stamp[slot] = now_ticks;
                  end
                  want.status = RS_INCOMPLETE;
                  want.fld.send_valid = 1'b1;
                  want.fld.send_dest_mac = MAC_BROADCAST;
                  want.fld.send_target_ip = f.lookup_ip;
               end else begin
                  want.status = RS_FOUND;
                  want.fld.resolved_mac = slot_mac[slot];
               end
            end
         end
         OP_TICK: begin
            now_ticks = now_ticks + 32'd1;
            for (int i = 0; i < NUM_ENTRIES; i++)
               if (slot_state[i] != ENT_FREE &&
                   (now_ticks - slot_stamp[i]) > {16'd0, cfg_timeout}) begin
                  slot_state[i] = ENT_FREE;
                  slot_ip[i] = '0;
                  slot_mac[i] = '0;
                  slot_stamp[i] = '0;
               end
            want.status = RS_TICK_DONE;
         end
         default: ;
      endcase
      awaited_answers.push_back(want);
   endtask

   function automatic logic [47:0] rand48();
      return {16'($urandom), $urandom};
   endfunction

   function automatic arp_fields_type random_fields();
      arp_fields_type f;
      f.pad = '0;
      f.lookup_ip = $urandom;
      f.target_ip = $urandom;
      f.sender_ip = $urandom;
      f.sender_mac = rand48();
      f.arp_op = 16'($urandom);
      f.proto_len = 8'($urandom);
      f.hw_len = 8'($urandom);
      f.proto_type = 16'($urandom);
      f.hw_type = 16'($urandom);
      f.msg_len = 11'($urandom);
      return f;
   endfunction

   function automatic arp_item_type rx_item(input logic [10:0] len, input logic [15:0] htype,
                                            input logic [7:0] hlen, input logic [15:0] ptype,
                                            input logic [7:0] plen, input logic [15:0] op,
                                            input logic [47:0] smac, input logic [31:0] sip,
                                            input logic [31:0] tip);
      arp_item_type it;
      it.opcode = OP_RX;
      it.fields = random_fields();
      it.fields.msg_len = len;
      it.fields.hw_type = htype;
      it.fields.hw_len = hlen;
      it.fields.proto_type = ptype;
      it.fields.proto_len = plen;
      it.fields.arp_op = op;
      it.fields.sender_mac = smac;
      it.fields.sender_ip = sip;
      it.fields.target_ip = tip;
      return it;
   endfunction

   function automatic arp_item_type good_rx(input logic [15:0] op, input logic [47:0] smac,
                                            input logic [31:0] sip, input logic [31:0] tip);
      return rx_item(MIN_MSG_LEN, HW_ETHER, HW_ADDR_LEN, PROTO_IPV4, PROTO_ADDR_LEN,
                     op, smac, sip, tip);
   endfunction

   function automatic arp_item_type plain_item(input logic [1:0] opcode,
                                               input logic [31:0] ip);
      arp_item_type it;
      it.opcode = opcode;
      it.fields = random_fields();
      it.fields.lookup_ip = ip;
      return it;
   endfunction

   function automatic logic [31:0] pool_ip();
      return ip_pool[$urandom_range(0, ip_pool.size() - 1)];
   endfunction

   // mostly well-formed traffic against a small address pool, plus broken headers and noise
   function automatic arp_item_type random_item();
      arp_item_type it;
      int           pick;
      int           r;
      logic [15:0]  op;
      logic [31:0]  tip;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         r = $urandom_range(0, 19);
         op = (r < 9) ? ARP_CODE_REQ : (r < 16) ? ARP_CODE_REP : 16'($urandom);
         r = $urandom_range(0, 19);
         tip = (r < 14) ? cfg_local_ip : (r < 17) ? pool_ip() : $urandom;
         it = good_rx(op, rand48(), pool_ip(), tip);
         if ($urandom_range(0, 3) == 0)
            it.fields.msg_len = 11'($urandom_range(28, 2047));
      end else if (pick < 48) begin
         it = good_rx(16'($urandom), rand48(), pool_ip(), cfg_local_ip);
         case ($urandom_range(0, 4))
            0: it.fields.msg_len = 11'($urandom_range(0, 27));
            1: it.fields.hw_type = 16'($urandom);
            2: it.fields.hw_len = 8'($urandom);
            3: it.fields.proto_type = 16'($urandom);
            default: it.fields.proto_len = 8'($urandom);
         endcase
      end else if (pick < 78) begin
         it = plain_item(OP_RESOLVE, ($urandom_range(0, 6) != 0) ? pool_ip() : $urandom);
      end else if (pick < 94) begin
         it = plain_item(OP_TICK, $urandom);
      end else begin
         it.opcode = 2'($urandom);
         it.fields = random_fields();
      end
      return it;
   endfunction

   task automatic refill_pool(input int n);
      ip_pool.delete();
      ip_pool.push_back(32'h0000_0000);
      ip_pool.push_back(32'hFFFF_FFFF);
      while (ip_pool.size() < n)
         ip_pool.push_back($urandom);
   endtask

   task automatic write_reg(input arpc_reg_type idx, input logic [63:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_LOCAL_IP:   cfg_local_ip = value[31:0];
         REG_LOCAL_MAC:  cfg_local_mac = value[47:0];
         REG_TIMEOUT:    cfg_timeout = value[15:0];
         REG_IFACE:      cfg_iface = value[0];
         REG_DEVICE_ETH: cfg_ether = value[0];
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (queued_msgs.size() != 0 || req_tvalid || awaited_answers.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic run_phase(input logic [31:0] ip, input logic [47:0] mac,
                            input logic [15:0] tmo, input logic iface, input logic eth,
                            input int pool_n, input int n_items);
      write_reg(REG_LOCAL_IP, {32'd0, ip});
      write_reg(REG_LOCAL_MAC, {16'd0, mac});
      write_reg(REG_TIMEOUT, {48'd0, tmo});
      write_reg(REG_IFACE, {63'd0, iface});
      write_reg(REG_DEVICE_ETH, {63'd0, eth});
      refill_pool(pool_n);
      ip_pool.push_back(ip);
      repeat (n_items) queued_msgs.push_back(random_item());
      wait_idle();
   endtask

   // sender: bursts of items separated by random gaps
   arp_item_type on_bus;
   int           burst_left = 0;
   int           gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            arp_table_step(on_bus);
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0 || queued_msgs.size() == 0) begin
               if (gap_left != 0)
                  gap_left--;
               req_tvalid <= 1'b0;
            end else begin
               on_bus = queued_msgs.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= on_bus.opcode;
               req_tdata <= on_bus.fields;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 20);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 45);
               end else begin
                  burst_left--;
               end
            end
         end
      end
   end

   // long receiver hold-off now and then, so the block backs up into its input
   int hold_left = 0;
   int hold_count = 0;

   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_count <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (req_tvalid && req_tready) begin
         hold_count <= hold_count + 1;
         if (hold_count % 400 == 150)
            hold_left <= 300;
      end
   end

   // receiver: check each item against the oldest prediction, stall on a changing pattern
   int   stall_mode = 0;
   int   mode_left = 0;
   logic parity = 1'b0;

   always @(posedge clock) begin : rsp_check
      arp_answer_type     want;
      arp_rsp_fields_type got;
      logic               ready_now;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (awaited_answers.size() == 0) begin
               report_mismatch($sformatf("response with none pending, status %0d", rsp_tuser));
            end else begin
               want = awaited_answers.pop_front();
               if (rsp_tuser != want.status)
                  report_mismatch($sformatf("status %0d, want %0d", rsp_tuser, want.status));
               if (got.send_valid != want.fld.send_valid)
                  report_mismatch($sformatf("send_valid %0b, want %0b",
                                            got.send_valid, want.fld.send_valid));
               if (got.send_is_reply != want.fld.send_is_reply)
                  report_mismatch($sformatf("send_is_reply %0b, want %0b",
                                            got.send_is_reply, want.fld.send_is_reply));
               if (got.send_dest_mac != want.fld.send_dest_mac)
                  report_mismatch($sformatf("send_dest_mac %h, want %h",
                                            got.send_dest_mac, want.fld.send_dest_mac));
               if (got.send_target_mac != want.fld.send_target_mac)
                  report_mismatch($sformatf("send_target_mac %h, want %h",
                                            got.send_target_mac, want.fld.send_target_mac));
               if (got.send_target_ip != want.fld.send_target_ip)
                  report_mismatch($sformatf("send_target_ip %h, want %h",
                                            got.send_target_ip, want.fld.send_target_ip));
               if (got.resolved_mac != want.fld.resolved_mac)
                  report_mismatch($sformatf("resolved_mac %h, want %h",
                                            got.resolved_mac, want.fld.resolved_mac));
            end
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 4);
            mode_left = $urandom_range(20, 200);
         end else begin
            mode_left--;
         end
         parity = ~parity;
         case (stall_mode)
            0: ready_now = 1'b1;
            1: ready_now = ($urandom_range(0, 3) == 0);
            2: ready_now = parity;
            3: ready_now = ($urandom_range(0, 1) == 0);
            default: ready_now = ($urandom_range(0, 15) != 0);
         endcase
         rsp_tready <= ready_now && (hold_left == 0);
      end
   end

   initial begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         slot_state[i] = ENT_FREE;
         slot_ip[i] = '0;
         slot_mac[i] = '0;
         slot_stamp[i] = '0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset settings: local address 0, timeout 30
      refill_pool(4);
      queued_msgs.push_back(rx_item(11'd27, HW_ETHER, HW_ADDR_LEN, PROTO_IPV4, PROTO_ADDR_LEN,
                                    ARP_CODE_REQ, rand48(), 32'hC0A8_0002, 32'h0));
      queued_msgs.push_back(rx_item(11'd0, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF,
                                    MAC_BROADCAST, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      queued_msgs.push_back(rx_item(11'd2047, 16'h0000, HW_ADDR_LEN, PROTO_IPV4, PROTO_ADDR_LEN,
                                    ARP_CODE_REQ, rand48(), 32'hC0A8_0002, 32'h0));
      queued_msgs.push_back(rx_item(MIN_MSG_LEN, HW_ETHER, 8'd0, PROTO_IPV4, PROTO_ADDR_LEN,
                                    ARP_CODE_REQ, rand48(), 32'hC0A8_0002, 32'h0));
      queued_msgs.push_back(rx_item(MIN_MSG_LEN, HW_ETHER, HW_ADDR_LEN, 16'h86DD, PROTO_ADDR_LEN,
                                    ARP_CODE_REQ, rand48(), 32'hC0A8_0002, 32'h0));
      queued_msgs.push_back(rx_item(MIN_MSG_LEN, HW_ETHER, HW_ADDR_LEN, PROTO_IPV4, 8'd16,
                                    ARP_CODE_REQ, rand48(), 32'hC0A8_0002, 32'h0));
      queued_msgs.push_back(rx_item(11'd2047, HW_ETHER, HW_ADDR_LEN, PROTO_IPV4, PROTO_ADDR_LEN,
                                    ARP_CODE_REQ, MAC_BROADCAST, 32'hC0A8_0002, 32'h0));
      queued_msgs.push_back(plain_item(OP_RESOLVE, 32'hC0A8_0002));
      queued_msgs.push_back(plain_item(OP_RESOLVE, 32'hC0A8_0003));
      queued_msgs.push_back(plain_item(OP_RESOLVE, 32'hC0A8_0003));
      queued_msgs.push_back(good_rx(ARP_CODE_REP, 48'h0, 32'hC0A8_0003, 32'h0));
      queued_msgs.push_back(plain_item(OP_RESOLVE, 32'hC0A8_0003));
      queued_msgs.push_back(good_rx(ARP_CODE_REQ, rand48(), 32'h0A00_0009, 32'h0A00_00FE));
      queued_msgs.push_back(plain_item(OP_RESOLVE, 32'h0A00_0009));
      queued_msgs.push_back(good_rx(16'hFFFF, rand48(), 32'h0A00_0009, 32'h0A00_00FE));
      queued_msgs.push_back(plain_item(OP_RESOLVE, 32'h0A00_0009));
      queued_msgs.push_back(plain_item(OP_TICK, $urandom));
      queued_msgs.push_back(plain_item(OP_UNUSED, $urandom));
      queued_msgs.push_back(good_rx(16'h0000, 48'h0, 32'hFFFF_FFFF, 32'h0));
      queued_msgs.push_back(plain_item(OP_RESOLVE, 32'hFFFF_FFFF));
      queued_msgs.push_back(plain_item(OP_RESOLVE, 32'h0));
      wait_idle();

      run_phase(32'h0A00_0001, rand48(), 16'd8, 1'b1, 1'b1, 40, 260);
      run_phase(32'hFFFF_FFFF, MAC_BROADCAST, 16'hFFFF, 1'b1, 1'b1, 12, 200);
      run_phase(32'h0, 48'h0, 16'd1, 1'b1, 1'b1, 40, 180);
      run_phase($urandom, rand48(), 16'd3, 1'b0, 1'b1, 20, 120);
      run_phase($urandom, rand48(), 16'd20, 1'b1, 1'b0, 20, 100);
      run_phase($urandom, rand48(), 16'd0, 1'b1, 1'b1, 8, 80);
      run_phase($urandom, rand48(), 16'd6, 1'b1, 1'b1, 48, 180);

      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/arpc_pkg.sv
hw/rtl/arpc_table.sv
hw/rtl/arpc_scan.sv
hw/rtl/arp_cache_engine.sv
sim/tb_arp_cache_engine.sv
